FILE: hdl/sqf_pkg.sv
// ----------------------------------------------------------------------------
// sqf_pkg
// Shared types and constants of the square forms factorizer.
// ----------------------------------------------------------------------------
package sqf_pkg;

	localparam int WORD_W = 64;   // working word of the expansion
	localparam int ROOT_W = 32;   // floor(sqrt(D)) of a 64-bit D

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic              start;
		logic [1:0]        op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] res;   // product, quotient or root
		logic [WORD_W-1:0] rem;   // remainder or sqrt residual
	} alu_rsp_t;

endpackage

FILE: hdl/sqf_alu.sv
// ----------------------------------------------------------------------------
// sqf_alu
// Shared bit-serial unit: 64-bit truncated multiply, 64-bit restoring
// divide and 64-bit integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module sqf_alu
	import sqf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [1:0]        op_q;
	logic [5:0]        cnt_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] acc_q;

	logic [WORD_W:0]   div_part;
	logic              div_ge;
	logic [WORD_W-1:0] sq_sum;

	assign div_part = {acc_q, x_q[WORD_W-1]};
	assign div_ge   = div_part >= {1'b0, y_q};
	assign sq_sum   = acc_q + y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == '0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
				end
			end else if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					OP_MUL: begin
						acc_q <= '0;
						x_q   <= req.a;
						y_q   <= req.b;
						cnt_q <= 6'(WORD_W - 1);
					end
					OP_DIV: begin
						acc_q <= '0;
						x_q   <= req.a;
						y_q   <= req.b;
						cnt_q <= 6'(WORD_W - 1);
					end
					default: begin
						acc_q <= '0;
						x_q   <= req.a;
						y_q   <= {2'b01, {(WORD_W-2){1'b0}}};
						cnt_q <= 6'(WORD_W/2 - 1);
					end
				endcase
			end
		end else begin
			cnt_q <= cnt_q - 6'd1;
			case (op_q)
				OP_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= {x_q[WORD_W-2:0], 1'b0};
					y_q <= {1'b0, y_q[WORD_W-1:1]};
				end
				OP_DIV: begin
					if (div_ge) begin
						acc_q <= WORD_W'(div_part - {1'b0, y_q});
					end else begin
						acc_q <= div_part[WORD_W-1:0];
					end
					x_q <= {x_q[WORD_W-2:0], div_ge};
				end
				default: begin
					if (x_q >= sq_sum) begin
						x_q   <= x_q - sq_sum;
						acc_q <= {1'b0, acc_q[WORD_W-1:1]} + y_q;
					end else begin
						acc_q <= {1'b0, acc_q[WORD_W-1:1]};
					end
					y_q <= {2'b00, y_q[WORD_W-1:2]};
				end
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		case (op_q)
			OP_MUL: begin
				rsp.res = acc_q;
				rsp.rem = '0;
			end
			OP_DIV: begin
				rsp.res = x_q;
				rsp.rem = acc_q;
			end
			default: begin
				rsp.res = acc_q;
				rsp.rem = x_q;
			end
		endcase
	end

endmodule

FILE: hdl/square_forms_factorizer.sv
// ----------------------------------------------------------------------------
// square_forms_factorizer
// Shanks' square forms factorization of one integer per request.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with number valid; the request is taken at a clock edge where
//   start is high and busy is low. busy stays high until the result is out.
//   The result shows on found/factor, which hold it; done marks it for exactly
//   one cycle and the receiver cannot stall it. factor is 0 whenever found is 0.
//   Registers (APB, pready always high): 0x0 multiplier k (reset 1),
//   0x4 max_iterations, the step cap of each loop (reset 65536). Write them
//   only while busy is low.
// Operation:
//   All multiplies, divides and square roots run through one bit-serial
//   unit (one bit per cycle), so time is set by that unit. One expansion
//   step costs a divide plus a multiply, and a square root is added on
//   every even forward step. Setup is a multiply (k * number) and a square
//   root; the switch to the reverse loop is a divide, a multiply and a
//   divide; the final gcd takes one divide per Euclid step. At most about
//   2 * max_iterations steps are taken. One request at a time.
// Reset:
//   arst_n clears the sequencer and loads the register reset values.
// ----------------------------------------------------------------------------
module square_forms_factorizer
	import sqf_pkg::*;
#(
	parameter int N_BITS = 56
)
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic [55:0] number,
	// result channel
	output logic        done,
	output logic        found,
	output logic [55:0] factor,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_MULT = 1'b0;
	localparam logic REG_ITER = 1'b1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KN   = 4'd1;
	localparam logic [3:0] S_ROOT = 4'd2;
	localparam logic [3:0] S_STEP = 4'd3;
	localparam logic [3:0] S_DIVW = 4'd4;
	localparam logic [3:0] S_MULW = 4'd5;
	localparam logic [3:0] S_ADV  = 4'd6;
	localparam logic [3:0] S_SQW  = 4'd7;
	localparam logic [3:0] S_B0W  = 4'd8;
	localparam logic [3:0] S_PSQ  = 4'd9;
	localparam logic [3:0] S_QW   = 4'd10;
	localparam logic [3:0] S_GCD  = 4'd11;
	localparam logic [3:0] S_GCDW = 4'd12;
	localparam logic [3:0] S_FAIL = 4'd13;

	// configuration registers
	logic [7:0]  mult_q;
	logic [23:0] max_q;

	// sequencer and datapath registers
	logic [3:0]        state_q;
	logic              rev_q;     // reverse loop active
	logic              add_q;     // q update adds the product
	logic [23:0]       count_q;
	logic [N_BITS-1:0] n_q;
	logic [WORD_W-1:0] d_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] plast_q;
	logic [ROOT_W-1:0] p_q;
	logic [WORD_W-1:0] qlast_q;
	logic [WORD_W-1:0] qcur_q;
	logic [WORD_W-1:0] qn_q;
	logic [WORD_W-1:0] ga_q;
	logic [WORD_W-1:0] gb_q;

	alu_req_t req_q;
	alu_rsp_t rsp;

	// next-state values of the sequencer
	logic [3:0] state_d;
	alu_req_t   req_d;
	logic       done_d;

	// step arithmetic
	logic [ROOT_W:0]   x_sum;     // root + plast
	logic [ROOT_W:0]   q_lim;     // 2*root + 1
	logic [ROOT_W:0]   bq;
	logic [ROOT_W:0]   p_new;
	logic [ROOT_W-1:0] p_diff;
	logic              p_down;
	logic [WORD_W-1:0] n_ext;

	assign x_sum  = {1'b0, root_q} + {1'b0, plast_q};
	assign q_lim  = {root_q, 1'b1};
	assign bq     = x_sum - rsp.rem[ROOT_W:0];
	assign p_new  = bq - {1'b0, plast_q};
	assign p_down = plast_q >= p_new[ROOT_W-1:0];
	assign p_diff = p_down ? plast_q - p_new[ROOT_W-1:0] : p_new[ROOT_W-1:0] - plast_q;
	assign n_ext  = WORD_W'(n_q);

	function automatic alu_req_t mk_req(input logic [1:0] op, input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		alu_req_t r;
		r.start = 1'b1;
		r.op    = op;
		r.a     = a;
		r.b     = b;
		return r;
	endfunction

	sqf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= 8'd1;
			max_q  <= 24'd65536;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MULT) begin
				mult_q <= pwdata[7:0];
			end else begin
				max_q <= pwdata[23:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MULT: prdata = {24'd0, mult_q};
			REG_ITER: prdata = {8'd0, max_q};
			default:  prdata = '0;
		endcase
	end

	assign busy = state_q != S_IDLE;

	// sequencer control: next state, unit request and result strobe
	always_comb begin
		state_d = state_q;
		req_d   = '0;
		done_d  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d   = mk_req(OP_MUL, WORD_W'(mult_q),
						WORD_W'(number[N_BITS-1:0]));
					state_d = S_KN;
				end
			end
			S_KN: begin
				if (rsp.done) begin
					req_d   = mk_req(OP_SQRT, rsp.res, '0);
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				if (rsp.done) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (count_q >= max_q) begin
					state_d = S_FAIL;
				end else if (qcur_q == '0 || qcur_q > WORD_W'(q_lim) ||
					plast_q > root_q) begin
					state_d = S_FAIL;
				end else begin
					req_d   = mk_req(OP_DIV, WORD_W'(x_sum), qcur_q);
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				if (rsp.done) begin
					if (bq < {1'b0, plast_q} || p_new > {1'b0, root_q}) begin
						state_d = S_FAIL;
					end else if (rev_q && p_new[ROOT_W-1:0] == plast_q) begin
						state_d = S_GCD;
					end else begin
						req_d   = mk_req(OP_MUL, rsp.res, WORD_W'(p_diff));
						state_d = S_MULW;
					end
				end
			end
			S_MULW: begin
				if (rsp.done) begin
					if (!rev_q && !count_q[0]) begin
						req_d   = mk_req(OP_SQRT, qcur_q, '0);
						state_d = S_SQW;
					end else begin
						state_d = S_ADV;
					end
				end
			end
			S_ADV: begin
				state_d = S_STEP;
			end
			S_SQW: begin
				if (rsp.done) begin
					if (rsp.rem != '0) begin
						state_d = S_ADV;
					end else if (rsp.res == '0 || plast_q > root_q) begin
						state_d = S_FAIL;
					end else begin
						req_d   = mk_req(OP_DIV, WORD_W'(root_q - plast_q), rsp.res);
						state_d = S_B0W;
					end
				end
			end
			S_B0W: begin
				if (rsp.done) begin
					req_d   = mk_req(OP_MUL, WORD_W'(root_q - rsp.rem[ROOT_W-1:0]),
						WORD_W'(root_q - rsp.rem[ROOT_W-1:0]));
					state_d = S_PSQ;
				end
			end
			S_PSQ: begin
				if (rsp.done) begin
					req_d   = mk_req(OP_DIV, d_q - rsp.res, qlast_q);
					state_d = S_QW;
				end
			end
			S_QW: begin
				if (rsp.done) begin
					state_d = S_STEP;
				end
			end
			S_GCD: begin
				if (gb_q == '0) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					req_d   = mk_req(OP_DIV, ga_q, gb_q);
					state_d = S_GCDW;
				end
			end
			S_GCDW: begin
				if (rsp.done) begin
					state_d = S_GCD;
				end
			end
			S_FAIL: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			req_q   <= req_d;
			done    <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q <= number[N_BITS-1:0];
			end
			S_KN: begin
				if (rsp.done) begin
					d_q <= rsp.res;
				end
			end
			S_ROOT: begin
				if (rsp.done) begin
					root_q  <= rsp.res[ROOT_W-1:0];
					plast_q <= rsp.res[ROOT_W-1:0];
					qlast_q <= WORD_W'(1);
					qcur_q  <= rsp.rem;
					count_q <= 24'd1;
					rev_q   <= 1'b0;
				end
			end
			S_DIVW: begin
				if (rsp.done) begin
					p_q   <= p_new[ROOT_W-1:0];
					add_q <= p_down;
					ga_q  <= n_ext;
					gb_q  <= WORD_W'(p_new[ROOT_W-1:0]);
				end
			end
			S_MULW: begin
				if (rsp.done) begin
					qn_q <= add_q ? qlast_q + rsp.res : qlast_q - rsp.res;
				end
			end
			S_ADV: begin
				// advance the expansion by one form
				plast_q <= p_q;
				qlast_q <= qcur_q;
				qcur_q  <= qn_q;
				count_q <= count_q + 24'd1;
			end
			S_SQW: begin
				if (rsp.done && rsp.rem == '0) begin
					qlast_q <= rsp.res;
				end
			end
			S_B0W: begin
				if (rsp.done) begin
					plast_q <= root_q - rsp.rem[ROOT_W-1:0];
				end
			end
			S_QW: begin
				if (rsp.done) begin
					qcur_q  <= rsp.res;
					count_q <= '0;
					rev_q   <= 1'b1;
				end
			end
			S_GCD: begin
				if (gb_q == '0) begin
					found  <= ga_q != WORD_W'(1) && ga_q != n_ext;
					factor <= (ga_q != WORD_W'(1) && ga_q != n_ext) ? 56'(ga_q) : '0;
				end
			end
			S_GCDW: begin
				if (rsp.done) begin
					ga_q <= gb_q;
					gb_q <= rsp.rem;
				end
			end
			S_FAIL: begin
				found  <= 1'b0;
				factor <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: test/tb_square_forms_factorizer.sv
// ----------------------------------------------------------------------------
// tb_square_forms_factorizer
// Self-checking bench for the square forms factorizer.
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake with random gaps. The bench
// also sets the multiplier and the step cap over the APB port. Each accepted
// request is run through a local SQUFOF model built on 64-bit wrapping
// arithmetic. Every done strobe is compared with the oldest queued
// expectation. Candidate numbers whose step count would run past a budget
// are dropped before they are sent, so the run length stays bounded.
// ----------------------------------------------------------------------------

class factor_ledger;
	logic [7:0]  mult;
	logic [23:0] cap;
	logic [56:0] pending_factors[$];   // {found, factor}
	int          errors;

	function new();
		mult   = 8'd1;
		cap    = 24'd65536;
		errors = 0;
	endfunction

	function void set_reg(int idx, logic [31:0] val);
		if (idx == 0)
			mult = val[7:0];
		else
			cap = val[23:0];
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (x >= r + bit_v) begin
				x = x - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	// one continued-fraction step; 0 when a bound is broken
	function automatic bit cf_advance(logic [63:0] root, logic [63:0] pl, logic [63:0] ql,
			logic [63:0] qc, output logic [63:0] pn, output logic [63:0] qn);
		logic [63:0] b, bq;
		pn = 0;
		qn = 0;
		if (qc == 0 || qc > 2 * root + 1 || pl > root)
			return 0;
		b = (root + pl) / qc;
		bq = b * qc;
		if (bq < pl)
			return 0;
		pn = bq - pl;
		if (pn > root)
			return 0;
		if (pl >= pn)
			qn = ql + b * (pl - pn);
		else
			qn = ql - b * (pn - pl);
		return 1;
	endfunction

	// Predict one request. Returns 0 when the step count passes limit.
	function automatic bit factorize(logic [55:0] n_in, int unsigned limit,
			output bit ok, output logic [55:0] g_out);
		logic [63:0] n, d, root, pl, ql, qc, p, q, s, b0, a, t, cnt;
		int unsigned steps;
		bit square;
		ok = 0;
		g_out = 0;
		steps = 0;
		square = 0;
		n = {8'd0, n_in};
		d = {56'd0, mult} * n;
		root = isqrt(d);
		pl = root;
		ql = 1;
		qc = d - root * root;
		for (cnt = 1; cnt < cap; cnt++) begin
			steps++;
			if (steps > limit)
				return 0;
			if (!cf_advance(root, pl, ql, qc, p, q))
				return 1;
			if (cnt[0] == 1'b0) begin
				s = isqrt(qc);
				if (s * s == qc) begin
					square = 1;
					break;
				end
			end
			pl = p;
			ql = qc;
			qc = q;
		end
		if (!square)
			return 1;
		s = isqrt(qc);
		if (s == 0 || pl > root)
			return 1;
		b0 = (root - pl) / s;
		pl = b0 * s + pl;
		ql = s;
		qc = (d - pl * pl) / s;
		for (cnt = 0; cnt < cap; cnt++) begin
			steps++;
			if (steps > limit)
				return 0;
			if (!cf_advance(root, pl, ql, qc, p, q))
				return 1;
			if (p == pl) begin
				a = n;
				t = p;
				while (t != 0) begin
					b0 = a % t;
					a = t;
					t = b0;
				end
				if (a == 1 || a == n)
					return 1;
				ok = 1;
				g_out = a[55:0];
				return 1;
			end
			pl = p;
			ql = qc;
			qc = q;
		end
		return 1;
	endfunction

	function void note_request(logic [55:0] n);
		bit ok;
		logic [55:0] g;
		void'(factorize(n, 32'hFFFF_FFFF, ok, g));
		pending_factors.push_back({ok, g});
	endfunction

	function void check_result(logic fnd, logic [55:0] fac);
		logic [56:0] exp_v;
		if (pending_factors.size() == 0) begin
			$display("%0t: unexpected result found=%0d factor=%0d", $time, fnd, fac);
			errors++;
			return;
		end
		exp_v = pending_factors.pop_front();
		if (fnd !== exp_v[56]) begin
			$display("%0t: found expected %0d actual %0d", $time, exp_v[56], fnd);
			errors++;
		end
		if (fac !== exp_v[55:0]) begin
			$display("%0t: factor expected %0d actual %0d", $time, exp_v[55:0], fac);
			errors++;
		end
	endfunction
endclass

module tb_square_forms_factorizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REG_MULT  = 0;
	localparam int REG_CAP   = 1;
	localparam int STALL_MAX = 3000000;   // idle cycles before giving up
	localparam int HUGE_N    = 3000;      // step budget for directed requests

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [55:0] number;
	logic        done;
	logic        found;
	logic [55:0] factor;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	factor_ledger ledger = new();
	int           stall_cnt;

	square_forms_factorizer #(.N_BITS(56)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .number(number),
		.done(done), .found(found), .factor(factor),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor: log each accepted request, check each result strobe.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			ledger.note_request(number);
		if (arst_n && done)
			ledger.check_result(found, factor);
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// Hold off until every request has come back and the block is idle.
	// Wait for a clock edge first so that a request taken at that edge is logged.
	task automatic wait_idle();
		@(posedge clk);
		while (ledger.pending_factors.size() != 0 || busy)
			@(posedge clk);
	endtask

	// APB write: setup then access; the model is updated at the commit edge.
	task automatic write_reg(int idx, logic [31:0] val);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		ledger.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly short gaps, a few long ones, a quarter with none.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// Send one request unless its predicted step count is over budget.
	// The gap counts from the edge after the previous handshake.
	task automatic send_request(logic [55:0] n, int unsigned budget);
		bit ok;
		logic [55:0] g;
		int gap;
		if (!ledger.factorize(n, budget, ok, g))
			return;
		gap = pick_gap();
		repeat (gap + 1) @(posedge clk);
		start  <= 1'b1;
		number <= n;
		do
			@(posedge clk);
		while (busy);
		start  <= 1'b0;
	endtask

	// Random value of w bits; widths are mostly narrow so that the expansion ends early.
	function automatic logic [55:0] rand_bits(int w);
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		if (w >= 56)
			return v[55:0];
		return v[55:0] & ((56'd1 << w) - 1);
	endfunction

	// Odd composite p*q, or raw noise now and then.
	function automatic logic [55:0] rand_number(int max_w);
		logic [55:0] p, q;
		int wp, wq;
		if ($urandom_range(0, 4) == 0)
			return rand_bits($urandom_range(2, 56)) | 56'd2;
		wp = $urandom_range(2, max_w / 2);
		wq = $urandom_range(2, max_w - wp);
		p = rand_bits(wp) | 56'd3;
		q = rand_bits(wq) | 56'd3;
		return p * q;
	endfunction

	initial begin
		int unsigned budget;
		int max_w;
		int cnt;
		arst_n  = 1'b0;
		start   = 1'b0;
		number  = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: small numbers, squares, primes, a prime power
		send_request(56'd2, HUGE_N);
		send_request(56'd3, HUGE_N);
		send_request(56'd4, HUGE_N);
		send_request(56'd15, HUGE_N);
		send_request(56'd49, HUGE_N);       // perfect square: zero divisor
		send_request(56'd77, HUGE_N);
		send_request(56'd97, HUGE_N);
		send_request(56'd1001, HUGE_N);
		send_request(56'd10403, HUGE_N);
		send_request(56'd11111, HUGE_N);

		// multiplier zero: D is 0, zero divisor at once
		write_reg(REG_MULT, 32'd0);
		send_request(56'd15, HUGE_N);
		// caps below the loop start: neither loop runs
		write_reg(REG_MULT, 32'd1);
		write_reg(REG_CAP, 32'd0);
		send_request(56'd15, HUGE_N);
		write_reg(REG_CAP, 32'd1);
		send_request(56'd77, HUGE_N);

		// extremes of the number at cap 2 and the largest multiplier
		write_reg(REG_MULT, 32'd255);
		write_reg(REG_CAP, 32'd2);
		send_request(56'hFF_FFFF_FFFF_FFFF, HUGE_N);
		send_request(56'hFF_FFFF_FFFF_FFFE, HUGE_N);
		send_request(56'hAA_AAAA_AAAA_AAAA, HUGE_N);
		send_request(56'h55_5555_5555_5555, HUGE_N);
		send_request(56'h80_0000_0000_0000, HUGE_N);

		// widest cap, tiny numbers so both loops end on their own
		write_reg(REG_MULT, 32'd3);
		write_reg(REG_CAP, 32'hFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_request(rand_number(16), 600);

		// random phases: new multiplier and cap, then a batch of requests
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_MULT, 32'd1);
				1: write_reg(REG_MULT, 32'd255);
				default: write_reg(REG_MULT, $urandom_range(1, 255));
			endcase
			write_reg(REG_CAP, (ph == 0) ? 32'd2 : $urandom_range(2, 60));
			cnt = 0;
			while (cnt < 10) begin
				max_w  = ($urandom_range(0, 3) == 0) ? 56 : $urandom_range(6, 24);
				budget = 400;
				send_request(rand_number(max_w), budget);
				cnt++;
			end
		end

		// drain, then give the block a moment to settle
		wait_idle();
		repeat (200) @(posedge clk);
		if (ledger.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: files.f
hdl/sqf_pkg.sv
hdl/sqf_alu.sv
hdl/square_forms_factorizer.sv
test/tb_square_forms_factorizer.sv
